// ===== rtl/core/c8eu_pkg.sv =====
`default_nettype none

package c8eu_pkg;

  localparam int unsigned CmdW  = 5;
  localparam int unsigned RegW  = 4;
  localparam int unsigned ByteW = 8;
  localparam int unsigned AddrW = 12;
  localparam int unsigned KeyW  = 16;
  localparam int unsigned IdxW  = 16;

  localparam logic [AddrW-1:0] PcReset = 12'h200;
  localparam logic [RegW-1:0]  FlagReg = 4'hF;

  typedef enum logic [CmdW-1:0] {
    CMD_RET     = 5'd0,
    CMD_JP      = 5'd1,
    CMD_CALL    = 5'd2,
    CMD_SE_KK   = 5'd3,
    CMD_SNE_KK  = 5'd4,
    CMD_SE_XY   = 5'd5,
    CMD_LD_KK   = 5'd6,
    CMD_ADD_KK  = 5'd7,
    CMD_LD_XY   = 5'd8,
    CMD_OR      = 5'd9,
    CMD_AND     = 5'd10,
    CMD_XOR     = 5'd11,
    CMD_ADD     = 5'd12,
    CMD_SUB     = 5'd13,
    CMD_SHR     = 5'd14,
    CMD_SUBN    = 5'd15,
    CMD_SHL     = 5'd16,
    CMD_SNE_XY  = 5'd17,
    CMD_LD_I    = 5'd18,
    CMD_JP_V0   = 5'd19,
    CMD_RND     = 5'd20,
    CMD_SKP     = 5'd21,
    CMD_SKNP    = 5'd22,
    CMD_LD_X_DT = 5'd23,
    CMD_LD_DT   = 5'd24,
    CMD_LD_ST   = 5'd25,
    CMD_ADD_I   = 5'd26,
    CMD_BCD     = 5'd27
  } cmd_e;

endpackage

`default_nettype wire

// ===== rtl/core/c8eu_cmd_if.sv =====
`default_nettype none

interface c8eu_cmd_if import c8eu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CmdW-1:0]  command;
  logic [RegW-1:0]  reg_x;
  logic [RegW-1:0]  reg_y;
  logic [ByteW-1:0] imm_byte;
  logic [AddrW-1:0] target_addr;
  logic [KeyW-1:0]  keys_down;
  logic [ByteW-1:0] random_byte;

  modport source (
    output valid, command, reg_x, reg_y, imm_byte, target_addr, keys_down, random_byte,
    input  ready
  );
  modport sink (
    input  valid, command, reg_x, reg_y, imm_byte, target_addr, keys_down, random_byte,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/c8eu_res_if.sv =====
`default_nettype none

interface c8eu_res_if import c8eu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [AddrW-1:0] next_pc;
  logic [IdxW-1:0]  index_value;
  logic             mem_write;
  logic [IdxW-1:0]  mem_addr;
  logic [ByteW-1:0] mem_data;
  logic             last;
  logic             stack_fault;

  modport source (
    output valid, next_pc, index_value, mem_write, mem_addr, mem_data, last, stack_fault,
    input  ready
  );
  modport sink (
    input  valid, next_pc, index_value, mem_write, mem_addr, mem_data, last, stack_fault,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/chip8_execute_unit_top.sv =====
// Pipeline: register file / return stack are read at acceptance into the execute stage,
// which executes into the output register once that register is free.
// Throughput: one request per cycle while the output is not stalled; BCD holds the
// execute stage for its three memory writes. Register file and stack writes are bypassed.
// Reset: registers V0..VF, index, timers and stack level clear, PC = 0x200;
// the return stack memory is not cleared.
`default_nettype none

module chip8_execute_unit_top import c8eu_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  c8eu_cmd_if.sink   cmd_i,
  c8eu_res_if.source res_o
);

  localparam int unsigned LvlW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SaW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned NumRegs = 1 << RegW;

  // storage
  logic [ByteW-1:0] rf_mem [NumRegs];
  logic [AddrW-1:0] stk_mem [STACK_DEPTH];

  // architectural flops
  logic [NumRegs-1:0] rf_vld_q, rf_vld_d;
  logic [ByteW-1:0]   vf_q, vf_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [AddrW-1:0]   pc_q, pc_d;
  logic [LvlW-1:0]    lvl_q, lvl_d;
  logic [ByteW-1:0]   dt_q, dt_d;
  logic [ByteW-1:0]   st_q, st_d;

  // execute stage
  logic             s1_vld_q;
  logic [1:0]       cnt_q;
  cmd_e             cmd_q;
  logic [RegW-1:0]  x_q;
  logic [ByteW-1:0] kk_q;
  logic [AddrW-1:0] addr_q;
  logic [KeyW-1:0]  keys_q;
  logic [ByteW-1:0] rnd_q;
  logic [ByteW-1:0] rdx_q, rdy_q;
  logic             vldx_q, vldy_q, xf_q, yf_q;
  logic             bypx_q, bypy_q;
  logic [ByteW-1:0] byp_data_q;
  logic [AddrW-1:0] stk_rd_q, stk_byp_data_q;
  logic             stk_byp_q;

  // output register
  logic             out_vld_q;
  logic [AddrW-1:0] o_pc_q;
  logic [IdxW-1:0]  o_idx_q;
  logic             o_we_q;
  logic [IdxW-1:0]  o_addr_q;
  logic [ByteW-1:0] o_data_q;
  logic             o_last_q;
  logic             o_fault_q;

  logic in_fire, out_free, fire, is_bcd, done;
  logic [RegW-1:0] ra_x, ra_y;
  logic [SaW-1:0]  sa_rd, sa_wr;
  logic [LvlW-1:0] lvl_m1;

  logic [ByteW-1:0] vx, vy;
  logic [AddrW-1:0] tos, pc_inc, pc_n;
  logic             skip, fault, x_we, f_we, push;
  logic [ByteW-1:0] x_val, f_val, dt_n, st_n;
  logic [IdxW-1:0]  idx_n;
  logic [LvlW-1:0]  lvl_n;
  logic [ByteW:0]   sum9;
  logic             rf_we, stk_we;

  logic [1:0]       hund;
  logic [ByteW-1:0] rem;
  logic [14:0]      tens_prod;
  logic [3:0]       tens;
  logic [ByteW-1:0] ones, digit;

  assign in_fire  = cmd_i.valid && cmd_i.ready;
  assign out_free = !out_vld_q || res_o.ready;
  assign fire     = s1_vld_q && out_free;
  assign is_bcd   = (cmd_q == CMD_BCD);
  assign done     = fire && (!is_bcd || cnt_q == 2'd2);
  assign cmd_i.ready = !s1_vld_q || done;

  // operands with bypass from the instruction that committed as this one was read
  assign vx  = xf_q ? vf_q : (bypx_q ? byp_data_q : (vldx_q ? rdx_q : '0));
  assign vy  = yf_q ? vf_q : (bypy_q ? byp_data_q : (vldy_q ? rdy_q : '0));
  assign tos = stk_byp_q ? stk_byp_data_q : stk_rd_q;

  assign pc_inc = pc_q + AddrW'(2);
  assign sum9   = {1'b0, vx} + {1'b0, vy};

  always_comb begin
    pc_n  = pc_inc;
    skip  = 1'b0;
    fault = 1'b0;
    x_we  = 1'b0;
    x_val = '0;
    f_we  = 1'b0;
    f_val = '0;
    idx_n = idx_q;
    dt_n  = dt_q;
    st_n  = st_q;
    lvl_n = lvl_q;
    push  = 1'b0;
    case (cmd_q)
      CMD_RET: begin
        if (lvl_q == '0) begin
          fault = 1'b1;
        end else begin
          lvl_n = lvl_q - LvlW'(1);
          pc_n  = tos;
        end
      end
      CMD_JP: pc_n = addr_q;
      CMD_CALL: begin
        if (lvl_q >= LvlW'(STACK_DEPTH)) begin
          fault = 1'b1;
        end else begin
          push  = 1'b1;
          lvl_n = lvl_q + LvlW'(1);
          pc_n  = addr_q;
        end
      end
      CMD_SE_KK:  skip = (vx == kk_q);
      CMD_SNE_KK: skip = (vx != kk_q);
      CMD_SE_XY:  skip = (vx == vy);
      CMD_SNE_XY: skip = (vx != vy);
      CMD_LD_KK: begin
        x_we = 1'b1; x_val = kk_q;
      end
      CMD_ADD_KK: begin
        x_we = 1'b1; x_val = vx + kk_q;
      end
      CMD_LD_XY: begin
        x_we = 1'b1; x_val = vy;
      end
      CMD_OR: begin
        x_we = 1'b1; x_val = vx | vy;
      end
      CMD_AND: begin
        x_we = 1'b1; x_val = vx & vy;
      end
      CMD_XOR: begin
        x_we = 1'b1; x_val = vx ^ vy;
      end
      CMD_ADD: begin
        x_we = 1'b1; x_val = sum9[ByteW-1:0];
        f_we = 1'b1; f_val = {7'b0, sum9[ByteW]};
      end
      CMD_SUB: begin
        x_we = 1'b1; x_val = vx - vy;
        f_we = 1'b1; f_val = {7'b0, (vx >= vy)};
      end
      CMD_SHR: begin
        x_we = 1'b1; x_val = {1'b0, vx[ByteW-1:1]};
        f_we = 1'b1; f_val = {7'b0, vx[0]};
      end
      CMD_SUBN: begin
        x_we = 1'b1; x_val = vy - vx;
        f_we = 1'b1; f_val = {7'b0, (vy >= vx)};
      end
      CMD_SHL: begin
        x_we = 1'b1; x_val = {vx[ByteW-2:0], 1'b0};
        f_we = 1'b1; f_val = {7'b0, vx[ByteW-1]};
      end
      CMD_LD_I:  idx_n = {4'b0, addr_q};
      CMD_JP_V0: pc_n = addr_q + {4'b0, vy};  // vy holds V0 here
      CMD_RND: begin
        x_we = 1'b1; x_val = rnd_q & kk_q;
      end
      CMD_SKP:  skip = keys_q[vx[3:0]];
      CMD_SKNP: skip = !keys_q[vx[3:0]];
      CMD_LD_X_DT: begin
        x_we = 1'b1; x_val = dt_q;
      end
      CMD_LD_DT: dt_n = vx;
      CMD_LD_ST: st_n = vx;
      CMD_ADD_I: idx_n = idx_q + {8'b0, vx};
      CMD_BCD: ;
      default: ;
    endcase
    if (skip) begin
      pc_n = pc_inc + AddrW'(2);
    end
  end

  // BCD digits: hundreds by compare, tens by reciprocal multiply (exact below 100)
  always_comb begin
    if (vx >= 8'd200) begin
      hund = 2'd2;
      rem  = vx - 8'd200;
    end else if (vx >= 8'd100) begin
      hund = 2'd1;
      rem  = vx - 8'd100;
    end else begin
      hund = 2'd0;
      rem  = vx;
    end
    tens_prod = rem[6:0] * 8'd205;
    tens      = tens_prod[14:11];
    ones      = rem - ({4'b0, tens} * 8'd10);
    case (cnt_q)
      2'd0:    digit = {6'b0, hund};
      2'd1:    digit = {4'b0, tens};
      default: digit = ones;
    endcase
  end

  // commit
  assign rf_we  = done && x_we && (x_q != FlagReg);
  assign stk_we = done && push;
  assign sa_wr  = lvl_q[SaW-1:0];

  always_comb begin
    pc_d     = done ? pc_n : pc_q;
    idx_d    = done ? idx_n : idx_q;
    dt_d     = done ? dt_n : dt_q;
    st_d     = done ? st_n : st_q;
    lvl_d    = done ? lvl_n : lvl_q;
    rf_vld_d = rf_vld_q;
    if (rf_we) begin
      rf_vld_d[x_q] = 1'b1;
    end
    vf_d = vf_q;
    if (done && f_we) begin
      vf_d = f_val;
    end else if (done && x_we && x_q == FlagReg) begin
      vf_d = x_val;
    end
  end

  // read addresses for the incoming request
  assign ra_x   = cmd_i.reg_x;
  assign ra_y   = (cmd_e'(cmd_i.command) == CMD_JP_V0) ? '0 : cmd_i.reg_y;
  assign lvl_m1 = lvl_d - LvlW'(1);
  assign sa_rd  = lvl_m1[SaW-1:0];

  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_mem[x_q] <= x_val;
    end
    if (stk_we) begin
      stk_mem[sa_wr] <= pc_inc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rdx_q          <= rf_mem[ra_x];
      rdy_q          <= rf_mem[ra_y];
      vldx_q         <= rf_vld_q[ra_x];
      vldy_q         <= rf_vld_q[ra_y];
      xf_q           <= (ra_x == FlagReg);
      yf_q           <= (ra_y == FlagReg);
      bypx_q         <= rf_we && (x_q == ra_x);
      bypy_q         <= rf_we && (x_q == ra_y);
      byp_data_q     <= x_val;
      stk_rd_q       <= stk_mem[sa_rd];
      stk_byp_q      <= stk_we && (sa_wr == sa_rd);
      stk_byp_data_q <= pc_inc;
      cmd_q          <= cmd_e'(cmd_i.command);
      x_q            <= cmd_i.reg_x;
      kk_q           <= cmd_i.imm_byte;
      addr_q         <= cmd_i.target_addr;
      keys_q         <= cmd_i.keys_down;
      rnd_q          <= cmd_i.random_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q <= '0;
      vf_q     <= '0;
      idx_q    <= '0;
      pc_q     <= PcReset;
      lvl_q    <= '0;
      dt_q     <= '0;
      st_q     <= '0;
      s1_vld_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      rf_vld_q <= rf_vld_d;
      vf_q     <= vf_d;
      idx_q    <= idx_d;
      pc_q     <= pc_d;
      lvl_q    <= lvl_d;
      dt_q     <= dt_d;
      st_q     <= st_d;
      if (in_fire) begin
        s1_vld_q <= 1'b1;
      end else if (done) begin
        s1_vld_q <= 1'b0;
      end
      if (done) begin
        cnt_q <= '0;
      end else if (fire) begin
        cnt_q <= cnt_q + 2'd1;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      o_pc_q    <= pc_n;
      o_idx_q   <= idx_n;
      o_we_q    <= is_bcd;
      o_addr_q  <= is_bcd ? (idx_q + {14'b0, cnt_q}) : '0;
      o_data_q  <= is_bcd ? digit : '0;
      o_last_q  <= !is_bcd || (cnt_q == 2'd2);
      o_fault_q <= fault;
    end
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.next_pc     = o_pc_q;
  assign res_o.index_value = o_idx_q;
  assign res_o.mem_write   = o_we_q;
  assign res_o.mem_addr    = o_addr_q;
  assign res_o.mem_data    = o_data_q;
  assign res_o.last        = o_last_q;
  assign res_o.stack_fault = o_fault_q;

endmodule

`default_nettype wire
